// ----- src/twodo_pkg.sv -----
`default_nettype none

package twodo_pkg;

  // Angles in radians, Q8.24
  localparam int Q24_PI       = 52707179;
  localparam int Q24_TWO_PI   = 105414357;
  localparam int Q24_HALF_PI  = 26353589;
  localparam int Q24_CORDIC_K = 10188014;

  // Operand and result widths of the shared units
  localparam int MUL_A_W = 40;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = 64;
  localparam int DIV_N_W = 58;
  localparam int DIV_D_W = 33;
  localparam int DIV_Q_W = DIV_N_W + 1;
  localparam int ANG_W   = 33;
  localparam int CRD_W   = 28;
  localparam int SAT_W   = 66;

  // Angle reduction: subtract 2*pi << k for k = RED_STEPS-1 down to 0
  localparam int RED_STEPS = 6;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_OFFSET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_OFFSET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRAFE_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_SOURCE = 3'd4;

  // Clamp a signed value to w bits (result still SAT_W wide)
  function automatic logic signed [SAT_W-1:0] sat_to(input logic signed [SAT_W-1:0] v,
                                                      input int unsigned w);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = (SAT_W'(1) <<< (w - 1)) - SAT_W'(1);
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // CORDIC arctangent of 2^-i, Q8.24
  function automatic logic signed [CRD_W-1:0] atan_step(input logic [4:0] i);
    logic signed [CRD_W-1:0] r;
    case (i)
      5'd0: r = 28'sd13176795;
      5'd1: r = 28'sd7778716;
      5'd2: r = 28'sd4110060;
      5'd3: r = 28'sd2086331;
      5'd4: r = 28'sd1047214;
      5'd5: r = 28'sd524117;
      5'd6: r = 28'sd262123;
      5'd7: r = 28'sd131069;
      5'd8: r = 28'sd65536;
      default: begin
        if (i <= 5'd24) begin
          r = CRD_W'(1) <<< (5'd24 - i);
        end else begin
          r = '0;
        end
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/twodo_mul.sv -----
`default_nettype none

module twodo_mul (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start_i,
  input  wire logic signed [twodo_pkg::MUL_A_W-1:0] a_i,
  input  wire logic signed [twodo_pkg::MUL_B_W-1:0] b_i,
  output logic                                  done_o,
  output logic signed [twodo_pkg::PROD_W-1:0]   prod_o
);
  import twodo_pkg::*;

  localparam int CW = $clog2(MUL_B_W);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic signed [PROD_W-1:0]   a_q, a_d;
  logic [MUL_B_W-1:0]         b_q, b_d;
  logic signed [PROD_W-1:0]   acc_q, acc_d;

  // One multiplier bit per cycle; the top bit of b weighs negative.
  // Partial sums may wrap; the final product is exact mod 2^PROD_W.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = PROD_W'(a_i);
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = (cnt_q == CW'(MUL_B_W - 1)) ? acc_q - a_q : acc_q + a_q;
      end
      a_d   = a_q <<< 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(MUL_B_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// ----- src/twodo_div.sv -----
`default_nettype none

module twodo_div (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    start_i,
  input  wire logic signed [twodo_pkg::DIV_N_W-1:0] num_i,
  input  wire logic signed [twodo_pkg::DIV_D_W-1:0] den_i,
  output logic                                   done_o,
  output logic signed [twodo_pkg::DIV_Q_W-1:0]   quo_o
);
  import twodo_pkg::*;

  localparam int CW = $clog2(DIV_N_W);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 neg_q, neg_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [DIV_N_W-1:0]   n_q, n_d;
  logic [DIV_D_W-1:0]   d_q, d_d;
  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_D_W:0]     trial;
  logic                 qbit;

  // Restoring division on magnitudes; quotient bits shift into n_q.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    n_d    = n_q;
    d_d    = d_q;
    rem_d  = rem_q;
    trial  = {rem_q, n_q[DIV_N_W-1]};
    qbit   = trial >= {1'b0, d_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = num_i[DIV_N_W-1] ^ den_i[DIV_D_W-1];
      n_d    = num_i[DIV_N_W-1] ? DIV_N_W'(-num_i) : DIV_N_W'(num_i);
      d_d    = den_i[DIV_D_W-1] ? DIV_D_W'(-den_i) : DIV_D_W'(den_i);
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? DIV_D_W'(trial - {1'b0, d_q}) : DIV_D_W'(trial);
      n_d   = {n_q[DIV_N_W-2:0], qbit};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DIV_N_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    n_q   <= n_d;
    d_q   <= d_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});

endmodule

`default_nettype wire

// ----- src/twodo_cordic.sv -----
`default_nettype none

module twodo_cordic #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  input  wire logic signed [twodo_pkg::ANG_W-1:0] ang_i,
  output logic                                 done_o,
  output logic signed [twodo_pkg::CRD_W-1:0]   sin_o,
  output logic signed [twodo_pkg::CRD_W-1:0]   cos_o
);
  import twodo_pkg::*;

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam int RW = $clog2(RED_STEPS);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_RED  = 2'd1;
  localparam logic [1:0] P_FOLD = 2'd2;
  localparam logic [1:0] P_ROT  = 2'd3;

  logic [1:0]              ph_q, ph_d;
  logic                    done_q, done_d;
  logic [RW-1:0]           rcnt_q, rcnt_d;
  logic [IW-1:0]           icnt_q, icnt_d;
  logic                    neg_q, neg_d;
  logic                    flip_q, flip_d;
  logic [ANG_W-1:0]        m_q, m_d;
  logic signed [CRD_W-1:0] x_q, x_d;
  logic signed [CRD_W-1:0] y_q, y_d;
  logic signed [CRD_W-1:0] a_q, a_d;
  logic [ANG_W-1:0]        sub_v;
  logic signed [CRD_W-1:0] av;
  logic signed [CRD_W-1:0] xs;
  logic signed [CRD_W-1:0] ys;
  logic signed [CRD_W-1:0] at;

  always_comb begin
    ph_d   = ph_q;
    done_d = 1'b0;
    rcnt_d = rcnt_q;
    icnt_d = icnt_q;
    neg_d  = neg_q;
    flip_d = flip_q;
    m_d    = m_q;
    x_d    = x_q;
    y_d    = y_q;
    a_d    = a_q;
    sub_v  = ANG_W'(Q24_TWO_PI) << rcnt_q;
    av     = neg_q ? -CRD_W'(m_q) : CRD_W'(m_q);
    xs     = x_q >>> icnt_q;
    ys     = y_q >>> icnt_q;
    at     = atan_step(5'(icnt_q));
    case (ph_q)
      P_IDLE: begin
        if (start_i) begin
          neg_d  = ang_i[ANG_W-1];
          m_d    = ang_i[ANG_W-1] ? ANG_W'(-ang_i) : ANG_W'(ang_i);
          rcnt_d = RW'(RED_STEPS - 1);
          ph_d   = P_RED;
        end
      end
      P_RED: begin
        // remainder keeps the sign of the angle
        if (m_q >= sub_v) begin
          m_d = m_q - sub_v;
        end
        if (rcnt_q == '0) begin
          ph_d = P_FOLD;
        end else begin
          rcnt_d = rcnt_q - RW'(1);
        end
      end
      P_FOLD: begin
        if (av > CRD_W'(Q24_PI)) begin
          av = av - CRD_W'(Q24_TWO_PI);
        end
        if (av < -CRD_W'(Q24_PI)) begin
          av = av + CRD_W'(Q24_TWO_PI);
        end
        flip_d = 1'b0;
        if (av > CRD_W'(Q24_HALF_PI)) begin
          av     = av - CRD_W'(Q24_PI);
          flip_d = 1'b1;
        end else if (av < -CRD_W'(Q24_HALF_PI)) begin
          av     = av + CRD_W'(Q24_PI);
          flip_d = 1'b1;
        end
        a_d    = av;
        x_d    = CRD_W'(Q24_CORDIC_K);
        y_d    = '0;
        icnt_d = '0;
        ph_d   = P_ROT;
      end
      P_ROT: begin
        if (a_q >= 0) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          a_d = a_q - at;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          a_d = a_q + at;
        end
        icnt_d = icnt_q + IW'(1);
        if (icnt_q == IW'(CORDIC_STEPS - 1)) begin
          ph_d   = P_IDLE;
          done_d = 1'b1;
        end
      end
      default: ph_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= P_IDLE;
      done_q <= 1'b0;
      rcnt_q <= '0;
      icnt_q <= '0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
      rcnt_q <= rcnt_d;
      icnt_q <= icnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    flip_q <= flip_d;
    m_q    <= m_d;
    x_q    <= x_d;
    y_q    <= y_d;
    a_q    <= a_d;
  end

  assign done_o = done_q;
  assign sin_o  = flip_q ? -y_q : y_q;
  assign cos_o  = flip_q ? -x_q : x_q;

endmodule

`default_nettype wire

// ----- src/tracking_wheel_odometry.sv -----
`default_nettype none

// Three-wheel arc odometry. Each sample transaction carries absolute left,
// right and strafe encoder counts and an external heading; tuser bit 0 set
// instead clears the pose. The block handles one sample at a time and holds
// s_axis_tready low while it works. Multiplies, divides and rotations run
// through three small iterative units under one sequencer: a bit-serial
// 40x32 multiplier, a restoring divider and a CORDIC. A sample on a straight
// path takes about 7 products, at most one quotient and one CORDIC run; a
// sample on an arc adds a CORDIC run, two quotients and two products. A
// pose-clear command skips the arithmetic and goes from idle straight to
// the output step. The result sits in an output register, so the next
// sample may enter while it waits. Configuration writes are always accepted
// and must only be issued while the block is idle.

module tracking_wheel_odometry #(
  parameter int CORDIC_STEPS   = 24,
  parameter int STRAIGHT_LIMIT = 17
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // left_count, right_count, strafe_count, ext_heading
  input  wire  [127:0] s_axis_tdata,
  // command
  input  wire  [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // pos_x, pos_y, heading_out
  output logic [111:0] m_axis_tdata,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [twodo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [23:0]  cfg_data_i
);
  import twodo_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DL   = 4'd1;
  localparam logic [3:0] S_DR   = 4'd2;
  localparam logic [3:0] S_DS   = 4'd3;
  localparam logic [3:0] S_HD   = 4'd4;
  localparam logic [3:0] S_SH   = 4'd5;
  localparam logic [3:0] S_LXD  = 4'd6;
  localparam logic [3:0] S_LXM  = 4'd7;
  localparam logic [3:0] S_LYD  = 4'd8;
  localparam logic [3:0] S_LYM  = 4'd9;
  localparam logic [3:0] S_AV   = 4'd10;
  localparam logic [3:0] S_X1   = 4'd11;
  localparam logic [3:0] S_X2   = 4'd12;
  localparam logic [3:0] S_Y1   = 4'd13;
  localparam logic [3:0] S_Y2   = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  localparam logic signed [31:0] LIM = 32'(STRAIGHT_LIMIT);

  logic [3:0]               state_q, state_d;
  logic                     go_q, go_d;
  logic                     out_valid_q, out_valid_d;
  logic [23:0]              dpc_q, dpc_d;
  logic [23:0]              lo_q, lo_d;
  logic [23:0]              ro_q, ro_d;
  logic [23:0]              so_q, so_d;
  logic                     hsrc_q, hsrc_d;
  logic [31:0]              prev_l_q, prev_l_d;
  logic [31:0]              prev_r_q, prev_r_d;
  logic [31:0]              prev_s_q, prev_s_d;
  logic signed [31:0]       head_q, head_d;
  logic signed [39:0]       x_acc_q, x_acc_d;
  logic signed [39:0]       y_acc_q, y_acc_d;

  logic signed [31:0]       l_q, l_d;
  logic signed [31:0]       r_q, r_d;
  logic signed [31:0]       s_q, s_d;
  logic signed [31:0]       ext_q, ext_d;
  logic signed [31:0]       hprev_q, hprev_d;
  logic signed [31:0]       dh_q, dh_d;
  logic signed [37:0]       rad_q, rad_d;
  logic signed [37:0]       lx_q, lx_d;
  logic signed [37:0]       ly_q, ly_d;
  logic signed [CRD_W-1:0]  sh_q, sh_d;
  logic signed [CRD_W-1:0]  sn_q, sn_d;
  logic signed [CRD_W-1:0]  c_q, c_d;
  logic signed [PROD_W-1:0] t_q, t_d;
  logic signed [39:0]       out_x_q, out_x_d;
  logic signed [39:0]       out_y_q, out_y_d;
  logic signed [31:0]       out_h_q, out_h_d;

  logic                      mul_start, mul_done;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_prod;
  logic                      div_start, div_done;
  logic signed [DIV_N_W-1:0] div_num;
  logic signed [DIV_D_W-1:0] div_den;
  logic signed [DIV_Q_W-1:0] div_quo;
  logic                      crd_start, crd_done;
  logic signed [ANG_W-1:0]   crd_ang;
  logic signed [CRD_W-1:0]   crd_sin, crd_cos;

  logic [24:0]               track;
  logic signed [32:0]        dlr;
  logic                      div_needed;
  logic                      in_acc;

  assign track      = {1'b0, lo_q} + {1'b0, ro_q};
  assign dlr        = 33'(l_q) - 33'(r_q);
  assign div_needed = !hsrc_q && (track != '0);
  assign in_acc     = s_axis_tvalid && s_axis_tready;

  // Unit launch: one start pulse on entry to an operation state
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    crd_start = 1'b0;
    if (!go_q) begin
      case (state_q)
        S_DL, S_DR, S_DS, S_LXM, S_LYM, S_X1, S_X2, S_Y1, S_Y2: mul_start = 1'b1;
        S_LXD, S_LYD: div_start = 1'b1;
        S_HD:         div_start = div_needed;
        S_SH, S_AV:   crd_start = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = $signed({16'd0, dpc_q});
    mul_b = l_q;
    case (state_q)
      S_DR:         mul_b = r_q;
      S_DS:         mul_b = s_q;
      S_LXM, S_LYM: begin
        mul_a = MUL_A_W'(rad_q);
        mul_b = MUL_B_W'(sh_q);
      end
      S_X1: begin
        mul_a = MUL_A_W'(lx_q);
        mul_b = MUL_B_W'(c_q);
      end
      S_X2: begin
        mul_a = MUL_A_W'(ly_q);
        mul_b = MUL_B_W'(sn_q);
      end
      S_Y1: begin
        mul_a = MUL_A_W'(ly_q);
        mul_b = MUL_B_W'(c_q);
      end
      S_Y2: begin
        mul_a = MUL_A_W'(lx_q);
        mul_b = MUL_B_W'(sn_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    div_num = DIV_N_W'($signed({dlr, 24'd0}));
    div_den = $signed({8'd0, track});
    case (state_q)
      S_LXD: begin
        div_num = DIV_N_W'($signed({s_q, 24'd0}));
        div_den = DIV_D_W'(dh_q);
      end
      S_LYD: begin
        div_num = DIV_N_W'($signed({r_q, 24'd0}));
        div_den = DIV_D_W'(dh_q);
      end
      default: ;
    endcase
  end

  assign crd_ang = (state_q == S_AV) ? ANG_W'(hprev_q) + ANG_W'(dh_q >>> 1)
                                     : ANG_W'(dh_q >>> 1);

  twodo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  twodo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  twodo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (crd_start),
    .ang_i   (crd_ang),
    .done_o  (crd_done),
    .sin_o   (crd_sin),
    .cos_o   (crd_cos)
  );

  always_comb begin
    logic signed [31:0]      dh_v;
    logic                    fin_v;
    logic signed [SAT_W-1:0] sum_v;
    state_d     = state_q;
    go_d        = go_q;
    out_valid_d = out_valid_q;
    dpc_d       = dpc_q;
    lo_d        = lo_q;
    ro_d        = ro_q;
    so_d        = so_q;
    hsrc_d      = hsrc_q;
    prev_l_d    = prev_l_q;
    prev_r_d    = prev_r_q;
    prev_s_d    = prev_s_q;
    head_d      = head_q;
    x_acc_d     = x_acc_q;
    y_acc_d     = y_acc_q;
    l_d         = l_q;
    r_d         = r_q;
    s_d         = s_q;
    ext_d       = ext_q;
    hprev_d     = hprev_q;
    dh_d        = dh_q;
    rad_d       = rad_q;
    lx_d        = lx_q;
    ly_d        = ly_q;
    sh_d        = sh_q;
    sn_d        = sn_q;
    c_d         = c_q;
    t_d         = t_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_h_d     = out_h_q;
    dh_v        = '0;
    fin_v       = 1'b0;
    sum_v       = '0;

    if (mul_start || div_start || crd_start) begin
      go_d = 1'b1;
    end else if (mul_done || div_done || crd_done) begin
      go_d = 1'b0;
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DIST_PER_COUNT: dpc_d  = cfg_data_i;
        CFG_LEFT_OFFSET:    lo_d   = cfg_data_i;
        CFG_RIGHT_OFFSET:   ro_d   = cfg_data_i;
        CFG_STRAFE_OFFSET:  so_d   = cfg_data_i;
        CFG_HEADING_SOURCE: hsrc_d = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser[0]) begin
            x_acc_d = '0;
            y_acc_d = '0;
            head_d  = '0;
            state_d = S_DONE;
          end else begin
            // count deltas wrap at 32 bits
            l_d      = s_axis_tdata[31:0] - prev_l_q;
            r_d      = s_axis_tdata[63:32] - prev_r_q;
            s_d      = s_axis_tdata[95:64] - prev_s_q;
            prev_l_d = s_axis_tdata[31:0];
            prev_r_d = s_axis_tdata[63:32];
            prev_s_d = s_axis_tdata[95:64];
            ext_d    = s_axis_tdata[127:96];
            hprev_d  = head_q;
            state_d  = S_DL;
          end
        end
      end
      S_DL: begin
        if (mul_done) begin
          l_d     = 32'(sat_to(SAT_W'(mul_prod >>> 8), 32));
          state_d = S_DR;
        end
      end
      S_DR: begin
        if (mul_done) begin
          r_d     = 32'(sat_to(SAT_W'(mul_prod >>> 8), 32));
          state_d = S_DS;
        end
      end
      S_DS: begin
        if (mul_done) begin
          s_d     = 32'(sat_to(SAT_W'(mul_prod >>> 8), 32));
          state_d = S_HD;
        end
      end
      S_HD: begin
        if (hsrc_q) begin
          dh_v   = 32'(sat_to(SAT_W'(ext_q) - SAT_W'(hprev_q), 32));
          head_d = ext_q;
          fin_v  = 1'b1;
        end else if (!div_needed) begin
          dh_v   = '0;
          head_d = hprev_q;
          fin_v  = 1'b1;
        end else if (div_done) begin
          dh_v   = 32'(sat_to(SAT_W'(div_quo), 32));
          head_d = 32'(sat_to(SAT_W'(hprev_q) + SAT_W'(dh_v), 32));
          fin_v  = 1'b1;
        end
        if (fin_v) begin
          dh_d = dh_v;
          if (dh_v <= LIM && dh_v >= -LIM) begin
            lx_d    = 38'(s_q);
            ly_d    = 38'(r_q);
            state_d = S_AV;
          end else begin
            state_d = S_SH;
          end
        end
      end
      S_SH: begin
        if (crd_done) begin
          sh_d    = crd_sin;
          state_d = S_LXD;
        end
      end
      S_LXD: begin
        if (div_done) begin
          rad_d   = 38'(sat_to(SAT_W'(div_quo) + SAT_W'($signed({1'b0, so_q})), 38));
          state_d = S_LXM;
        end
      end
      S_LXM: begin
        if (mul_done) begin
          lx_d    = 38'(sat_to(SAT_W'(mul_prod >>> 23), 38));
          state_d = S_LYD;
        end
      end
      S_LYD: begin
        if (div_done) begin
          rad_d   = 38'(sat_to(SAT_W'(div_quo) + SAT_W'($signed({1'b0, ro_q})), 38));
          state_d = S_LYM;
        end
      end
      S_LYM: begin
        if (mul_done) begin
          ly_d    = 38'(sat_to(SAT_W'(mul_prod >>> 23), 38));
          state_d = S_AV;
        end
      end
      S_AV: begin
        if (crd_done) begin
          sn_d    = crd_sin;
          c_d     = crd_cos;
          state_d = S_X1;
        end
      end
      S_X1: begin
        if (mul_done) begin
          t_d     = mul_prod;
          state_d = S_X2;
        end
      end
      S_X2: begin
        if (mul_done) begin
          sum_v   = SAT_W'(t_q) + SAT_W'(mul_prod);
          x_acc_d = 40'(sat_to(SAT_W'(x_acc_q) + (sum_v >>> 24), 40));
          state_d = S_Y1;
        end
      end
      S_Y1: begin
        if (mul_done) begin
          t_d     = mul_prod;
          state_d = S_Y2;
        end
      end
      S_Y2: begin
        if (mul_done) begin
          sum_v   = SAT_W'(t_q) - SAT_W'(mul_prod);
          y_acc_d = 40'(sat_to(SAT_W'(y_acc_q) + (sum_v >>> 24), 40));
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_x_d     = x_acc_q;
          out_y_d     = y_acc_q;
          out_h_d     = head_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
      dpc_q       <= 24'd402000;
      lo_q        <= 24'd458752;
      ro_q        <= 24'd458752;
      so_q        <= 24'd327680;
      hsrc_q      <= 1'b0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      prev_s_q    <= '0;
      head_q      <= '0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
    end else begin
      state_q     <= state_d;
      go_q        <= go_d;
      out_valid_q <= out_valid_d;
      dpc_q       <= dpc_d;
      lo_q        <= lo_d;
      ro_q        <= ro_d;
      so_q        <= so_d;
      hsrc_q      <= hsrc_d;
      prev_l_q    <= prev_l_d;
      prev_r_q    <= prev_r_d;
      prev_s_q    <= prev_s_d;
      head_q      <= head_d;
      x_acc_q     <= x_acc_d;
      y_acc_q     <= y_acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q     <= l_d;
    r_q     <= r_d;
    s_q     <= s_d;
    ext_q   <= ext_d;
    hprev_q <= hprev_d;
    dh_q    <= dh_d;
    rad_q   <= rad_d;
    lx_q    <= lx_d;
    ly_q    <= ly_d;
    sh_q    <= sh_d;
    sn_q    <= sn_d;
    c_q     <= c_d;
    t_q     <= t_d;
    out_x_q <= out_x_d;
    out_y_q <= out_y_d;
    out_h_q <= out_h_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_h_q, out_y_q, out_x_q};
  assign cfg_ready_o   = 1'b1;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_DL || state_q == S_DR || state_q == S_DS ||
                  state_q == S_LXM || state_q == S_LYM || state_q == S_X1 ||
                  state_q == S_X2 || state_q == S_Y1 || state_q == S_Y2))
    else $error("multiplier finished outside a multiply step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_HD || state_q == S_LXD || state_q == S_LYD))
    else $error("divider finished outside a divide step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    crd_done |-> (state_q == S_SH || state_q == S_AV))
    else $error("CORDIC finished outside a rotation step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser[0]) |=>
      (x_acc_q == '0 && y_acc_q == '0 && head_q == '0 && state_q == S_DONE))
    else $error("pose clear did not zero the accumulators");

endmodule

`default_nettype wire

// ----- tb/odometry_checker.sv -----
`timescale 1ns / 100ps

module odometry_checker (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  input  wire          s_axis_tready,
  input  wire  [127:0] s_axis_tdata,
  input  wire  [0:0]   s_axis_tuser,
  input  wire          m_axis_tvalid,
  input  wire          m_axis_tready,
  input  wire  [111:0] m_axis_tdata,
  input  wire          cfg_valid_i,
  input  wire          cfg_ready_o,
  input  wire  [twodo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [23:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           pose_count_o
);
  import twodo_pkg::*;

  localparam longint TURN_PI   = 52707179;
  localparam longint TURN_2PI  = 105414357;
  localparam longint TURN_HALF = 26353589;
  localparam longint GAIN_K    = 10188014;
  localparam int     STEPS     = 24;
  localparam longint STRAIGHT  = 17;

  // heading in the top bits, x in the lowest, as on m_axis_tdata
  typedef struct packed {
    logic signed [31:0] h;
    logic signed [39:0] y;
    logic signed [39:0] x;
  } pose_t;

  // predictor state
  logic [31:0] last_l, last_r, last_s;
  longint hdg, px, py;
  longint dist_per_cnt, off_l, off_r, off_s;
  bit     ext_src;
  pose_t  pose_q[$];

  function automatic longint clamp(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint arctan_lsb(int i);
    longint head[9];
    head = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069, 65536};
    if (i < 9) return head[i];
    if (i <= 24) return 64'sd1 <<< (24 - i);
    return 0;
  endfunction

  task automatic sin_cos(input longint ang, output longint s, output longint c);
    longint a, xv, yv, xs, ys;
    bit flip;
    a = ang % TURN_2PI;
    xv = GAIN_K;
    yv = 0;
    flip = 0;
    if (a > TURN_PI) a -= TURN_2PI;
    if (a < -TURN_PI) a += TURN_2PI;
    if (a > TURN_HALF) begin
      a -= TURN_PI; flip = 1;
    end else if (a < -TURN_HALF) begin
      a += TURN_PI; flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (a >= 0) begin
        xv -= ys; yv += xs; a -= arctan_lsb(i);
      end else begin
        xv += ys; yv -= xs; a += arctan_lsb(i);
      end
    end
    s = flip ? -yv : yv;
    c = flip ? -xv : xv;
  endtask

  function automatic longint wheel_travel(logic [31:0] now, logic [31:0] was);
    logic signed [31:0] d;
    d = now - was;
    return clamp((longint'(d) * dist_per_cnt) >>> 8, 32);
  endfunction

  function automatic longint arc_chord(longint d, longint dh, longint sh, longint off);
    longint rad;
    rad = clamp((d * (64'sd1 <<< 24)) / dh + off, 38);
    return clamp((rad * sh) >>> 23, 38);
  endfunction

  task automatic advance_pose(input bit clear, input logic [127:0] d);
    longint dl, dr, ds, h0, dh, lx, ly, sh, ch, s, c, trk;
    if (clear) begin
      hdg = 0; px = 0; py = 0;
    end else begin
      dl = wheel_travel(d[31:0], last_l);
      dr = wheel_travel(d[63:32], last_r);
      ds = wheel_travel(d[95:64], last_s);
      h0 = hdg;
      last_l = d[31:0];
      last_r = d[63:32];
      last_s = d[95:64];
      if (ext_src) begin
        dh = clamp(longint'($signed(d[127:96])) - h0, 32);
        hdg = longint'($signed(d[127:96]));
      end else begin
        trk = off_l + off_r;
        dh = (trk != 0) ? clamp(((dl - dr) * (64'sd1 <<< 24)) / trk, 32) : 0;
        hdg = clamp(h0 + dh, 32);
      end
      if (dh <= STRAIGHT && dh >= -STRAIGHT) begin
        lx = ds; ly = dr;
      end else begin
        sin_cos(dh >>> 1, sh, ch);
        lx = arc_chord(ds, dh, sh, off_s);
        ly = arc_chord(dr, dh, sh, off_r);
      end
      sin_cos(h0 + (dh >>> 1), s, c);
      px = clamp(px + ((lx * c + ly * s) >>> 24), 40);
      py = clamp(py + ((ly * c - lx * s) >>> 24), 40);
    end
    pose_q.push_back('{x: px[39:0], y: py[39:0], h: hdg[31:0]});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t got, want;
    if (!rst_ni) begin
      last_l = 0; last_r = 0; last_s = 0;
      hdg = 0; px = 0; py = 0;
      dist_per_cnt = 402000; off_l = 458752; off_r = 458752; off_s = 327680;
      ext_src = 0;
      pose_q.delete();
      fail_count_o <= 0;
      pose_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DIST_PER_COUNT: dist_per_cnt = cfg_data_i;
          CFG_LEFT_OFFSET:    off_l = cfg_data_i;
          CFG_RIGHT_OFFSET:   off_r = cfg_data_i;
          CFG_STRAFE_OFFSET:  off_s = cfg_data_i;
          CFG_HEADING_SOURCE: ext_src = cfg_data_i[0];
          default: ;
        endcase
      end
      // check before predicting: a result never leaves in the cycle its sample enters
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        pose_count_o <= pose_count_o + 1;
        if (pose_q.size() == 0) begin
          $display("%0t: unexpected pose, actual %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pose_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.h !== want.h) begin
            $display("%0t: pose mismatch, expected x=%0d y=%0d h=%0d actual x=%0d y=%0d h=%0d",
                     $time, want.x, want.y, want.h, got.x, got.y, got.h);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) advance_pose(s_axis_tuser[0], s_axis_tdata);
    end
  end

  assign pending_o = pose_q.size();
endmodule

// ----- tb/tb_tracking_wheel_odometry.sv -----
`timescale 1ns / 100ps

module tb_tracking_wheel_odometry;
  import twodo_pkg::*;

  logic          clk_i, rst_ni;
  logic          s_axis_tvalid, s_axis_tready;
  logic [127:0]  s_axis_tdata;
  logic [0:0]    s_axis_tuser;
  logic          m_axis_tvalid, m_axis_tready;
  logic [111:0]  m_axis_tdata;
  logic          cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [23:0]   cfg_data_i;
  int            fail_count, pending, pose_count;
  int            stall_mode;

  tracking_wheel_odometry uut (.*);

  odometry_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .pose_count_o(pose_count)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver stall pattern: phases of no stall, light and heavy stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: m_axis_tready <= 1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic send_sample(input bit clear, input logic [127:0] d);
    s_axis_tvalid <= 1;
    s_axis_tuser <= clear;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_sender(input int n);
    s_axis_tvalid <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  // leave the write channel idle after each write transaction
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    wait (pending == 0);
    @(posedge clk_i);
    wait (s_axis_tready);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] near(logic [31:0] base, int span);
    return base + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // small wheel steps with random content, sometimes wide jumps
  task automatic drive_phase(input int n);
    logic [31:0] l, r, s, h;
    int burst, span;
    l = $urandom; r = $urandom; s = $urandom; h = $urandom;
    burst = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      span = ($urandom_range(0, 3) == 0) ? 4000 : 300;
      case ($urandom_range(0, 19))
        0: send_sample(1, {$urandom, $urandom, $urandom, $urandom});
        1: begin
          l = $urandom; r = $urandom; s = $urandom; h = $urandom;
          send_sample(0, {h, s, r, l});
        end
        2: begin
          l = near(l, 100); r = l + (r - l) ; s = near(s, 100);
          send_sample(0, {h, s, l, l});
          r = l;
        end
        default: begin
          l = near(l, span); r = near(r, span); s = near(s, span); h = near(h, 20000000);
          send_sample(0, {h, s, r, l});
        end
      endcase
      if (--burst == 0) begin
        idle_sender($urandom_range(1, 30));
        burst = $urandom_range(1, 12);
      end
    end
    drain();
  endtask

  initial begin
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid_i = 0;
    cfg_index_i = CFG_DIST_PER_COUNT;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: first sample from zero, extremes, wrap, straight path, clear
    send_sample(0, {32'h0, 32'd100, 32'd100, 32'd100});
    send_sample(0, {32'h0, 32'h7fffffff, 32'h7fffffff, 32'h80000000});
    send_sample(0, {32'h0, 32'h80000000, 32'h80000000, 32'h7fffffff});
    send_sample(0, {32'h0, 32'h80000003, 32'h80000001, 32'h7ffffffd});
    send_sample(0, {32'hffffffff, 32'h0, 32'h0, 32'h0});
    send_sample(1, {4{32'hffffffff}});
    send_sample(0, {32'h0, 32'd5, 32'd40, 32'd41});
    send_sample(0, {32'h0, 32'h12345678, 32'h0badcafe, 32'h7654321f});
    drain();
    write_reg(CFG_HEADING_SOURCE, 24'd1);
    send_sample(0, {32'h7fffffff, 32'd10, 32'd20, 32'd30});
    send_sample(0, {32'h80000000, 32'd10, 32'd25, 32'd30});
    send_sample(0, {32'h80000008, 32'd300, 32'd25, 32'd30});
    send_sample(0, {32'h00000000, 32'h55555555, 32'haaaaaaaa, 32'h5a5a5a5a});
    send_sample(1, '0);
    drain();
    write_reg(CFG_LEFT_OFFSET, 24'd0);
    write_reg(CFG_RIGHT_OFFSET, 24'd0);
    write_reg(CFG_HEADING_SOURCE, 24'd0);
    write_reg(CFG_DIST_PER_COUNT, 24'hffffff);
    write_reg(CFG_STRAFE_OFFSET, 24'hffffff);
    send_sample(0, {32'h0, 32'h100, 32'h0, 32'hffff0000});
    send_sample(0, {32'h0, 32'h7fffffff, 32'h80000000, 32'h7fffffff});
    drain();

    // random phases over several settings, the extremes included
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          write_reg(CFG_DIST_PER_COUNT, 24'd402000);
          write_reg(CFG_LEFT_OFFSET, 24'd458752);
          write_reg(CFG_RIGHT_OFFSET, 24'd458752);
          write_reg(CFG_STRAFE_OFFSET, 24'd327680);
        end
        1: write_reg(CFG_HEADING_SOURCE, 24'd1);
        2: begin
          write_reg(CFG_HEADING_SOURCE, 24'd0);
          write_reg(CFG_DIST_PER_COUNT, 24'hffffff);
          write_reg(CFG_LEFT_OFFSET, 24'd1);
          write_reg(CFG_RIGHT_OFFSET, 24'd0);
        end
        3: begin
          write_reg(CFG_DIST_PER_COUNT, 24'd0);
          write_reg(CFG_STRAFE_OFFSET, 24'd0);
        end
        default: begin
          write_reg(CFG_DIST_PER_COUNT, 24'($urandom));
          write_reg(CFG_LEFT_OFFSET, 24'($urandom));
          write_reg(CFG_RIGHT_OFFSET, 24'($urandom));
          write_reg(CFG_STRAFE_OFFSET, 24'($urandom));
          write_reg(CFG_HEADING_SOURCE, 24'($urandom_range(0, 1)));
        end
      endcase
      drive_phase(145);
    end

    $display("Run covered %0d poses over directed extremes and seven register settings,",
             pose_count);
    $display("including external heading, zero track width and pose clears.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
